// ----- src/multiset_store_top_macros.svh -----
// ----------------------------------------------------------------------------
// multiset_store_top_macros.svh
// Assertion macros for the multiset store RTL, used by the sequencer (mss_seq).
// ----------------------------------------------------------------------------
`ifndef MULTISET_STORE_TOP_MACROS_SVH
`define MULTISET_STORE_TOP_MACROS_SVH

// Checked only while out of reset.
`define MSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define MSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/mss_pkg.sv -----
// ----------------------------------------------------------------------------
// mss_pkg
// Item types and operation codes for the multiset store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mss_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  entry_value;
    } req_t;

    typedef struct packed {
        logic               done_ok;
        logic [COUNT_W-1:0] occurrences;
        logic               is_present;
        logic [COUNT_W-1:0] stored_count;
        logic               is_empty;
    } rsp_t;

endpackage

// ----- src/mss_store.sv -----
// ----------------------------------------------------------------------------
// mss_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mss_store #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/mss_seq.sv -----
// ----------------------------------------------------------------------------
// mss_seq
// Operation sequencer: walks the stored entries through one shared equality
// comparator, tracks the fill count and builds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multiset_store_top_macros.svh"

module mss_seq
    import mss_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  req_t                 req,
    output logic                 ready,
    output logic                 mem_we,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_waddr,
    output logic [ITEM_WIDTH-1:0] mem_wdata,
    output logic                 mem_re,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_raddr,
    input  logic [ITEM_WIDTH-1:0] mem_rdata,
    output logic                 res_valid,
    output rsp_t                 res,
    input  logic                 res_take
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WIDE_W = CNT_W + COUNT_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_MOVE_RD = 3'd2;
    localparam logic [2:0] S_MOVE_WR = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]            state_reg,   state_next;
    logic [CNT_W-1:0]      fill_reg,    fill_next;
    logic [CNT_W-1:0]      ptr_reg,     ptr_next;
    logic [CNT_W-1:0]      cmp_ptr_reg, cmp_ptr_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0]      occ_reg,     occ_next;
    logic [IDX_W-1:0]      match_reg,   match_next;
    logic                  ok_reg,      ok_next;
    logic [OPCODE_W-1:0]   op_reg,      op_next;
    logic [ITEM_WIDTH-1:0] val_reg,     val_next;

    logic [ITEM_WIDTH+VALUE_W-1:0] val_wide;
    logic [ITEM_WIDTH-1:0]         value_in;
    logic                          hit;
    logic                          last_cmp;
    logic                          issue;
    logic [CNT_W-1:0]              last_idx;
    logic [WIDE_W-1:0]             occ_wide;
    logic [WIDE_W-1:0]             fill_wide;

    assign val_wide = {{ITEM_WIDTH{1'b0}}, req.entry_value};
    assign value_in = val_wide[ITEM_WIDTH-1:0];

    // shared comparator
    assign hit      = (mem_rdata == val_reg);
    assign last_cmp = ((cmp_ptr_reg + CNT_W'(1)) == fill_reg);
    assign issue    = (ptr_reg < fill_reg);
    assign last_idx = fill_reg - CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        cmp_ptr_next = cmp_ptr_reg;
        cmp_vld_next = cmp_vld_reg;
        occ_next     = occ_reg;
        match_next   = match_reg;
        ok_next      = ok_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        mem_we       = 1'b0;
        mem_waddr    = fill_reg[IDX_W-1:0];
        mem_wdata    = value_in;
        mem_re       = 1'b0;
        mem_raddr    = ptr_reg[IDX_W-1:0];
        res_valid    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req.opcode;
                    val_next     = value_in;
                    occ_next     = '0;
                    ok_next      = 1'b1;
                    ptr_next     = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = S_DONE;
                    unique case (req.opcode)
                        OP_ADD:
                        begin
                            if (fill_reg < CNT_W'(CAPACITY))
                            begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (fill_reg == '0)
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (fill_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read one entry per cycle; compare works on the registered read data
                mem_re       = issue;
                cmp_vld_next = issue;
                cmp_ptr_next = ptr_reg;
                if (issue)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (op_reg == OP_REMOVE && hit)
                    begin
                        match_next   = cmp_ptr_reg[IDX_W-1:0];
                        cmp_vld_next = 1'b0;
                        state_next   = S_MOVE_RD;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            occ_next = occ_reg + CNT_W'(1);
                        end
                        if (last_cmp)
                        begin
                            cmp_vld_next = 1'b0;
                            state_next   = S_DONE;
                            if (op_reg == OP_REMOVE)
                            begin
                                ok_next = 1'b0;
                            end
                        end
                    end
                end
            end

            S_MOVE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = last_idx[IDX_W-1:0];
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                // last entry fills the hole left by the removed one
                mem_we     = 1'b1;
                mem_waddr  = match_reg;
                mem_wdata  = mem_rdata;
                fill_next  = last_idx;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        cmp_ptr_reg <= cmp_ptr_next;
        occ_reg     <= occ_next;
        match_reg   <= match_next;
        ok_reg      <= ok_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
    end

    assign ready     = (state_reg == S_IDLE);
    assign occ_wide  = {{COUNT_W{1'b0}}, occ_reg};
    assign fill_wide = {{COUNT_W{1'b0}}, fill_reg};

    always_comb
    begin
        res.done_ok      = ok_reg;
        res.occurrences  = (op_reg == OP_QUERY) ? occ_wide[COUNT_W-1:0] : '0;
        res.is_present   = (op_reg == OP_QUERY) && (occ_reg != '0);
        res.stored_count = fill_wide[COUNT_W-1:0];
        res.is_empty     = (fill_reg == '0);
    end

    `MSS_ASSERT(a_fill_bound, fill_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `MSS_ASSERT(a_cmp_in_range, cmp_vld_reg |-> (cmp_ptr_reg < fill_reg), "compare past fill count")
    `MSS_ASSERT(a_fill_step, (fill_reg != $past(fill_reg)) |-> ((fill_reg == $past(fill_reg) + CNT_W'(1)) || (fill_reg + CNT_W'(1) == $past(fill_reg)) || (fill_reg == '0)), "fill count jumped")
    `MSS_ASSERT(a_move_write, (state_reg == S_MOVE_RD) |=> (mem_we && (state_reg == S_MOVE_WR)), "remove move lost its write")

endmodule

// ----- src/multiset_store_top.sv -----
// ----------------------------------------------------------------------------
// multiset_store_top
// Fixed-capacity multiset (bag) of values with add, remove, query and clear.
// ----------------------------------------------------------------------------
// One item is one operation and gives one result item. Add, clear and any
// operation on an empty bag skip the scan and go from the accept straight
// to the result. On a non-empty bag a query or a remove scans the stored
// entries: a single equality comparator reads the entry memory one entry
// per cycle behind its registered read data, and a remove that hits stops
// the scan and then spends one read and one write moving the last entry
// into the freed slot. The block takes one item at a time and stalls the
// input until the result moves to the output register; a finished result
// waits there while the next item is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiset_store_top
    import mss_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                  ready;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ITEM_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [ITEM_WIDTH-1:0] mem_rdata;
    logic                  res_valid;
    rsp_t                  res;
    logic                  res_take;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg,       rsp_next;

    mss_store #(
        .DEPTH  (CAPACITY),
        .WIDTH  (ITEM_WIDTH),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mss_seq #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .ready     (ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // output register frees up when empty or being taken this cycle
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign req_stall = !ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- tb/tb_multiset_store_top.sv -----
// ----------------------------------------------------------------------------
// tb_multiset_store_top
// Self-checking testbench for the multiset store.
// ----------------------------------------------------------------------------
// Each accepted item goes through a bag model that is kept inside the
// testbench, and the response it predicts is queued. Each result that the
// block hands over is compared field by field with the oldest queued
// response. The directed tests cover the empty bag, filling to capacity, a
// refused add when full, removes that hit and miss, queries, and clear. The
// random traffic then draws mostly from a small pool of values so that
// duplicates, matches and refusals keep coming. The sender works in bursts
// and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multiset_store_top;
    import mss_pkg::*;

    localparam int BAG_CAPACITY   = 16;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int SETTLE_CYCLES  = 40;
    localparam int POOL_SIZE      = 6;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // bag model state
    logic [VALUE_W-1:0] bag_slots [BAG_CAPACITY];
    int                 bag_fill;

    rsp_t               pending_rsps [$];
    int                 error_count;
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    multiset_store_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Apply one operation to the bag model and return the response it gives.
    function automatic rsp_t apply_bag_op(input req_t item);
        rsp_t r;
        int   hit;
        r = '0;
        r.done_ok = 1'b1;
        case (item.opcode)
            OP_ADD:
            begin
                if (bag_fill < BAG_CAPACITY)
                begin
                    bag_slots[bag_fill] = item.entry_value;
                    bag_fill++;
                end
                else
                    r.done_ok = 1'b0;
            end
            OP_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < bag_fill; i++)
                    if (hit < 0 && bag_slots[i] == item.entry_value)
                        hit = i;
                if (hit >= 0)
                begin
                    bag_fill--;
                    bag_slots[hit] = bag_slots[bag_fill];
                end
                else
                    r.done_ok = 1'b0;
            end
            OP_QUERY:
            begin
                for (int i = 0; i < bag_fill; i++)
                    if (bag_slots[i] == item.entry_value)
                        r.occurrences++;
                r.is_present = (r.occurrences != 0);
            end
            default:
                bag_fill = 0;
        endcase
        r.stored_count = bag_fill[COUNT_W-1:0];
        r.is_empty     = (bag_fill == 0);
        return r;
    endfunction

    // Present one item and hold it until accepted; caller is at a rising edge.
    task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
        req_t item;
        rsp_t predicted;
        item.opcode      = op;
        item.entry_value = value;
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predicted = apply_bag_op(item);
        pending_rsps.insert(pending_rsps.size(), predicted);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsps.size() != 0);
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_rsps.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, rsp);
                error_count++;
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp.done_ok !== want.done_ok)
                begin
                    $display("%0t: done_ok expected %0d actual %0d",
                             $time, want.done_ok, rsp.done_ok);
                    error_count++;
                end
                if (rsp.occurrences !== want.occurrences)
                begin
                    $display("%0t: occurrences expected %0d actual %0d",
                             $time, want.occurrences, rsp.occurrences);
                    error_count++;
                end
                if (rsp.is_present !== want.is_present)
                begin
                    $display("%0t: is_present expected %0d actual %0d",
                             $time, want.is_present, rsp.is_present);
                    error_count++;
                end
                if (rsp.stored_count !== want.stored_count)
                begin
                    $display("%0t: stored_count expected %0d actual %0d",
                             $time, want.stored_count, rsp.stored_count);
                    error_count++;
                end
                if (rsp.is_empty !== want.is_empty)
                begin
                    $display("%0t: is_empty expected %0d actual %0d",
                             $time, want.is_empty, rsp.is_empty);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: runs of never, always, heavy or light stalling.
    initial
    begin : stall_pattern
        int run_len;
        int mode;
        rsp_stall <= 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            run_len = (mode == 1) ? $urandom_range(1, 12) : $urandom_range(5, 60);
            repeat (run_len)
            begin
                @(posedge clk);
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= 1'b1;
                    2:       rsp_stall <= ($urandom_range(0, 1) == 1);
                    default: rsp_stall <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    task automatic test_empty_bag();
        send_op(OP_REMOVE, 32'h0000_0005);
        send_op(OP_QUERY, 32'h0000_0000);
        send_op(OP_CLEAR, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    task automatic test_fill_to_full();
        send_op(OP_ADD, 32'h0000_0000);
        send_op(OP_ADD, 32'hFFFF_FFFF);
        send_op(OP_ADD, 32'h0000_0000);
        for (int i = 3; i < BAG_CAPACITY; i++)
            send_op(OP_ADD, $urandom);
        // one add past capacity, refused
        send_op(OP_ADD, 32'h5A5A_5A5A);
        wait_for_results();
    endtask

    task automatic test_remove_and_query();
        send_op(OP_QUERY, 32'h0000_0000);
        send_op(OP_REMOVE, 32'h0000_0000);
        send_op(OP_REMOVE, 32'h1234_5678);
        send_op(OP_QUERY, 32'h0000_0000);
        wait_for_results();
    endtask

    task automatic test_clear();
        send_op(OP_CLEAR, $urandom);
        // stale contents must not be seen after clear
        send_op(OP_QUERY, 32'h0000_0000);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst_len;
        int bias;
        int pick;
        bit drained;
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  value;
        sent    = 0;
        drained = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        while (sent < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(1, 40);
            bias      = $urandom_range(0, 2);
            value_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
            repeat (burst_len)
            begin
                pick = $urandom_range(0, 99);
                case (bias)
                    0:       op = (pick < 60) ? OP_ADD : (pick < 78) ? OP_REMOVE :
                                  (pick < 98) ? OP_QUERY : OP_CLEAR;
                    1:       op = (pick < 20) ? OP_ADD : (pick < 65) ? OP_REMOVE :
                                  (pick < 98) ? OP_QUERY : OP_CLEAR;
                    default: op = (pick < 38) ? OP_ADD : (pick < 65) ? OP_REMOVE :
                                  (pick < 95) ? OP_QUERY : OP_CLEAR;
                endcase
                value = ($urandom_range(0, 99) < 85) ?
                        value_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
                send_op(op, value);
                sent++;
            end
            if (!drained && sent >= RANDOM_ITEMS / 2)
            begin
                wait_for_results();
                drained = 1;
            end
            else if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 20));
        end
        wait_for_results();
    endtask

    initial
    begin
        error_count = 0;
        bag_fill    = 0;
        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        req         <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_bag();
        test_fill_to_full();
        test_remove_and_query();
        test_clear();
        test_random_traffic();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
